@@ rtl/npm_pkg.sv @@
package npm_pkg;

    // Store geometry and field widths.
    localparam int MAX_ELEMENTS = 8;
    localparam int IDX_W        = $clog2(MAX_ELEMENTS);
    localparam int DATA_W       = 8;
    localparam int CNT_W        = 4;

    // Commands from the controller to the datapath.
    typedef enum logic [3:0] {
        CMD_NONE,
        CMD_LOAD,
        CMD_START,
        CMD_RD_IDX,
        CMD_PREV_FIRST,
        CMD_PIV_CMP,
        CMD_SUCC_CMP,
        CMD_SWAP2,
        CMD_REV_RD_LO,
        CMD_REV_RD_HI,
        CMD_REV_W1,
        CMD_REV_W2,
        CMD_EMIT_INIT,
        CMD_EMIT
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic lt;        // element just read is below its right neighbor
        logic gt;        // element just read is above the pivot
        logic idx_zero;  // scan index is at the first position
        logic idx_last;  // scan index is at the last position in use
        logic lo_lt_hi;  // reversal pointers have not met
    } t_dp_status;

    // Saturates a written count to 2..MAX_ELEMENTS and returns the last index.
    function automatic logic [IDX_W-1:0] last_index(input logic [CNT_W-1:0] value);
        logic [IDX_W-1:0] result;
        if (value < CNT_W'(2)) begin
            result = IDX_W'(1);
        end else if (value > CNT_W'(MAX_ELEMENTS)) begin
            result = IDX_W'(MAX_ELEMENTS - 1);
        end else begin
            result = IDX_W'(value - CNT_W'(1));
        end
        return result;
    endfunction

endpackage

@@ rtl/npm_ram.sv @@
module npm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // One write port and one registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/npm_dp.sv @@
module npm_dp
    import npm_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_dp_cmd            i_cmd,
    output t_dp_status         o_status,
    input  logic               i_cfg_we,
    input  logic [CNT_W-1:0]   i_cfg_data,
    input  logic [IDX_W-1:0]   i_position,
    input  logic [DATA_W-1:0]  i_element_value,
    output logic               o_strobe,
    output logic [IDX_W-1:0]   o_out_position,
    output logic [DATA_W-1:0]  o_out_value,
    output logic               o_is_last,
    output logic               o_no_next
);

    logic [IDX_W-1:0]  r_last_idx;
    logic [IDX_W-1:0]  r_idx;
    logic [IDX_W-1:0]  r_pivot;
    logic [IDX_W-1:0]  r_succ;
    logic [IDX_W-1:0]  r_lo;
    logic [IDX_W-1:0]  r_hi;
    logic [DATA_W-1:0] r_prev;
    logic [DATA_W-1:0] r_pval;
    logic [DATA_W-1:0] r_tmp;
    logic              r_no_next;
    logic              r_strobe;
    logic [IDX_W-1:0]  r_out_position;
    logic [DATA_W-1:0] r_out_value;
    logic              r_out_is_last;
    logic              r_out_no_next;

    logic              ram_we;
    logic [IDX_W-1:0]  ram_waddr;
    logic [DATA_W-1:0] ram_wdata;
    logic [IDX_W-1:0]  ram_raddr;
    logic [DATA_W-1:0] ram_rdata;

    npm_ram #(
        .WIDTH (DATA_W),
        .DEPTH (MAX_ELEMENTS)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // Status for the controller: comparisons on the word just read and checks on the pointers.
    assign o_status.lt       = ram_rdata < r_prev;
    assign o_status.gt       = ram_rdata > r_pval;
    assign o_status.idx_zero = r_idx == '0;
    assign o_status.idx_last = r_idx == r_last_idx;
    assign o_status.lo_lt_hi = r_lo < r_hi;

    // Read address selection.
    always_comb begin
        case (i_cmd)
            CMD_REV_RD_LO: ram_raddr = r_lo;
            CMD_REV_RD_HI: ram_raddr = r_hi;
            default:       ram_raddr = r_idx;
        endcase
    end

    // Write port selection: loads, the swap and the suffix reversal.
    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = r_idx;
        ram_wdata = ram_rdata;
        case (i_cmd)
            CMD_LOAD: begin
                ram_we    = 1'b1;
                ram_waddr = i_position;
                ram_wdata = i_element_value;
            end
            CMD_SUCC_CMP: begin
                ram_we    = o_status.gt;
                ram_waddr = r_pivot;
            end
            CMD_SWAP2: begin
                ram_we    = 1'b1;
                ram_waddr = r_succ;
                ram_wdata = r_pval;
            end
            CMD_REV_W1: begin
                ram_we    = 1'b1;
                ram_waddr = r_lo;
            end
            CMD_REV_W2: begin
                ram_we    = 1'b1;
                ram_waddr = r_hi;
                ram_wdata = r_tmp;
            end
            default: begin
                ram_we = 1'b0;
            end
        endcase
    end

    // Control registers: element count and result strobe.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_idx <= IDX_W'(MAX_ELEMENTS - 1);
            r_strobe   <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_last_idx <= last_index(i_cfg_data);
            end
            r_strobe <= i_cmd == CMD_EMIT;
        end
    end

    // Scan pointers, held values and the result register.
    always_ff @(posedge i_clk) begin
        case (i_cmd)
            CMD_START: begin
                r_idx     <= r_last_idx;
                r_no_next <= 1'b0;
            end
            CMD_PREV_FIRST: begin
                r_prev <= ram_rdata;
                r_idx  <= r_idx - IDX_W'(1);
            end
            CMD_PIV_CMP: begin
                if (o_status.lt) begin
                    r_pivot <= r_idx;
                    r_pval  <= ram_rdata;
                    r_idx   <= r_last_idx;
                end else if (o_status.idx_zero) begin
                    r_no_next <= 1'b1;
                end else begin
                    r_prev <= ram_rdata;
                    r_idx  <= r_idx - IDX_W'(1);
                end
            end
            CMD_SUCC_CMP: begin
                if (o_status.gt) begin
                    r_succ <= r_idx;
                    r_lo   <= r_pivot + IDX_W'(1);
                    r_hi   <= r_last_idx;
                end else begin
                    r_idx <= r_idx - IDX_W'(1);
                end
            end
            CMD_REV_RD_HI: begin
                r_tmp <= ram_rdata;
            end
            CMD_REV_W2: begin
                r_lo <= r_lo + IDX_W'(1);
                r_hi <= r_hi - IDX_W'(1);
            end
            CMD_EMIT_INIT: begin
                r_idx <= '0;
            end
            CMD_EMIT: begin
                r_out_position <= r_idx;
                r_out_value    <= ram_rdata;
                r_out_is_last  <= r_idx == r_last_idx;
                r_out_no_next  <= r_no_next;
                r_idx          <= r_idx + IDX_W'(1);
            end
            default: begin
            end
        endcase
    end

    assign o_strobe       = r_strobe;
    assign o_out_position = r_out_position;
    assign o_out_value    = r_out_value;
    assign o_is_last      = r_out_is_last;
    assign o_no_next      = r_out_no_next;

endmodule

@@ rtl/npm_ctrl.sv @@
module npm_ctrl
    import npm_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_start,
    input  logic       i_opcode,
    input  t_dp_status i_status,
    output t_dp_cmd    o_cmd,
    output logic       o_busy
);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_P_FIRST,
        ST_P_FIRSTW,
        ST_P_RD,
        ST_P_CMP,
        ST_S_RD,
        ST_S_CMP,
        ST_SWAP2,
        ST_R_CHK,
        ST_R_RD_HI,
        ST_R_W1,
        ST_R_W2,
        ST_E_RD,
        ST_E_OUT
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_busy;

    // Next state and datapath command.
    always_comb begin
        n_state = r_state;
        o_cmd   = CMD_NONE;
        unique case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    if (i_opcode) begin
                        o_cmd   = CMD_START;
                        n_state = ST_P_FIRST;
                    end else begin
                        o_cmd = CMD_LOAD;
                    end
                end
            end
            ST_P_FIRST: begin
                o_cmd   = CMD_RD_IDX;
                n_state = ST_P_FIRSTW;
            end
            ST_P_FIRSTW: begin
                o_cmd   = CMD_PREV_FIRST;
                n_state = ST_P_RD;
            end
            ST_P_RD: begin
                o_cmd   = CMD_RD_IDX;
                n_state = ST_P_CMP;
            end
            ST_P_CMP: begin
                o_cmd = CMD_PIV_CMP;
                if (i_status.lt) begin
                    n_state = ST_S_RD;
                end else if (i_status.idx_zero) begin
                    n_state = ST_E_RD;
                end else begin
                    n_state = ST_P_RD;
                end
            end
            ST_S_RD: begin
                o_cmd   = CMD_RD_IDX;
                n_state = ST_S_CMP;
            end
            ST_S_CMP: begin
                o_cmd   = CMD_SUCC_CMP;
                n_state = i_status.gt ? ST_SWAP2 : ST_S_RD;
            end
            ST_SWAP2: begin
                o_cmd   = CMD_SWAP2;
                n_state = ST_R_CHK;
            end
            ST_R_CHK: begin
                if (i_status.lo_lt_hi) begin
                    o_cmd   = CMD_REV_RD_LO;
                    n_state = ST_R_RD_HI;
                end else begin
                    o_cmd   = CMD_EMIT_INIT;
                    n_state = ST_E_RD;
                end
            end
            ST_R_RD_HI: begin
                o_cmd   = CMD_REV_RD_HI;
                n_state = ST_R_W1;
            end
            ST_R_W1: begin
                o_cmd   = CMD_REV_W1;
                n_state = ST_R_W2;
            end
            ST_R_W2: begin
                o_cmd   = CMD_REV_W2;
                n_state = ST_R_CHK;
            end
            ST_E_RD: begin
                o_cmd   = CMD_RD_IDX;
                n_state = ST_E_OUT;
            end
            ST_E_OUT: begin
                o_cmd   = CMD_EMIT;
                n_state = i_status.idx_last ? ST_IDLE : ST_E_RD;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // State register and registered busy flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_busy  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_busy  <= n_state != ST_IDLE;
        end
    end

    assign o_busy = r_busy;

endmodule

@@ rtl/next_permutation_multiset.sv @@
// Next lexicographic permutation of a stored sequence of up to eight bytes.
//
// A request is taken at a rising edge with start high and busy low. With
// i_opcode low it writes i_element_value at i_position and
// busy stays low. With i_opcode high it steps the first element_count
// positions to their next permutation and then emits one result per
// position, in order, on o_strobe; o_is_last marks the final one and
// o_no_next is set on all of them when the sequence was already the last
// permutation (it is then left unchanged). Results cannot be held off.
// An advance keeps busy high through the pivot scan, the successor scan,
// the swap, the reversal of the suffix and the read-out of the results:
// every step goes through the single read port of the store, whose read
// data is registered. The last result is on the ports in the cycle in
// which busy falls.
// The count register is written over i_cfg_valid/o_cfg_ready while the
// block is idle and no request is offered; values outside 2..8 are saturated.
// Reset returns the controller to idle and the count to 8. The store is not
// cleared; every position used must be loaded before the first advance.
module next_permutation_multiset
    import npm_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  logic              i_opcode,
    input  logic [IDX_W-1:0]  i_position,
    input  logic [DATA_W-1:0] i_element_value,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [CNT_W-1:0]  i_cfg_data,
    output logic              o_strobe,
    output logic [IDX_W-1:0]  o_out_position,
    output logic [DATA_W-1:0] o_out_value,
    output logic              o_is_last,
    output logic              o_no_next
);

    t_dp_cmd    cmd;
    t_dp_status status;

    // The count only changes while no advance is running or starting.
    assign o_cfg_ready = ~busy & ~start;

    npm_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_opcode (i_opcode),
        .i_status (status),
        .o_cmd    (cmd),
        .o_busy   (busy)
    );

    npm_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_status        (status),
        .i_cfg_we        (i_cfg_valid & o_cfg_ready),
        .i_cfg_data      (i_cfg_data),
        .i_position      (i_position),
        .i_element_value (i_element_value),
        .o_strobe        (o_strobe),
        .o_out_position  (o_out_position),
        .o_out_value     (o_out_value),
        .o_is_last       (o_is_last),
        .o_no_next       (o_no_next)
    );

    // A load request never makes the block busy.
    a_load_no_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy && !i_opcode |=> !busy)
        else $error("load request raised busy");

    // Busy only rises after an advance request.
    a_busy_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(busy) |-> $past(start) && $past(i_opcode))
        else $error("busy rose without an advance request");

    // The last result closes the sequence.
    a_last_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && o_is_last |=> !o_strobe)
        else $error("result follows the last one");

    // Results that are not last are followed by the next position.
    a_next_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && !o_is_last |-> ##2 (o_strobe &&
            o_out_position == IDX_W'($past(o_out_position, 2) + IDX_W'(1))))
        else $error("emitted positions out of order");

endmodule
